// ----- sv/lcc_pkg.sv -----
// Shared types and constants of the LSH collision counter.
`default_nettype none
package lcc_pkg;

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASHES_IN_USE  = 1'd1;
  localparam int CFG_DATA_W = 9;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_CANDIDATE = 1'b1;

  // Fixed field widths.
  localparam int QIDX_W  = 5;
  localparam int HIDX_W  = 8;
  localparam int HVAL_W  = 32;
  localparam int QUSE_W  = 6;
  localparam int HUSE_W  = 9;
  localparam int CNT_W   = 9;
  localparam int CNT_FIELD_MAX = 511;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic compare;  // stage one holds a candidate hash that is compared
    logic snap;     // stage one holds the final hash of a candidate
    logic shift;    // the count at the head of the chain has been taken
  } lcc_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/lcc_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/lcc_cell.sv -----
// One query cell: signature memory, saturating collision counter and a result shift stage.
`default_nettype none
module lcc_cell
  import lcc_pkg::*;
#(
  parameter int VW    = 32,
  parameter int DEPTH = 256,
  parameter int LIMIT = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lcc_ctrl_t        ctrl,
  input  wire logic             cell_en,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [VW-1:0]    wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic [VW-1:0]    cmp_value,
  input  wire logic [CNT_W-1:0] shift_in,
  output logic      [CNT_W-1:0] shift_out
);

  logic [VW-1:0]    sig;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             hit;

  lcc_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_sig_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (sig)
  );

  assign hit      = ctrl.compare && cell_en && (sig == cmp_value) && (cnt < CNT_W'(LIMIT));
  assign cnt_next = hit ? cnt + CNT_W'(1) : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.snap) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // The final count is captured on the last hash and then moves one cell
  // towards the head each time a result is taken.
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      shift_out <= cnt_next;
    end else if (ctrl.shift) begin
      shift_out <= shift_in;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lsh_collision_counter.sv -----
// Top level of the LSH collision counter: input staging, cell chain and result drain.
`default_nettype none
// The block keeps one cell per query, each with its own signature memory of
// NUM_HASHES entries and a saturating collision counter. Load transactions
// (tuser low) write one signature entry; candidate transactions (tuser high)
// are broadcast to every cell, which reads its stored hash at the same index
// and counts a collision when the values match. Loads and candidates are taken
// at one transaction per clock cycle while the input is not held: the
// signature read is registered and the compare follows in the next cycle, so
// the cells keep up with back-to-back hashes. When a candidate carries tlast
// the input is held: in the next cycle the final counts are captured into the
// shift stages of the chain and the counters cleared, after which one result
// per query in use (queries_in_use, at most NUM_QUERIES) leaves from the head
// of the chain, lowest query first, one per cycle while the output is ready.
// The input reopens when the final result is taken, or at the capture when no
// query is in use. The signature memories are not cleared at reset; counts
// read against entries that were never loaded are meaningless.
module lsh_collision_counter
  import lcc_pkg::*;
#(
  parameter int NUM_QUERIES = 32,
  parameter int NUM_HASHES  = 256,
  parameter int HASH_WIDTH  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata, from bit 0: query_index[4:0], hash_index[12:5], hash_value[44:13], zero fill
  input  wire logic [47:0]           s_tdata,
  // s_tuser: req_type
  input  wire logic                  s_tuser,
  input  wire logic                  s_tlast,
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata, from bit 0: result_query[4:0], hit_count[13:5], zero fill
  output logic [15:0]                m_tdata,
  output logic                       m_tlast
);

  localparam int VW    = (HASH_WIDTH >= HVAL_W) ? HVAL_W : HASH_WIDTH;
  localparam int AW    = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int QW    = $clog2(NUM_QUERIES + 1);
  localparam int PW    = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;
  localparam int LIMIT = (NUM_HASHES > CNT_FIELD_MAX) ? CNT_FIELD_MAX : NUM_HASHES;

  // Input fields.
  logic [QIDX_W-1:0] query_index;
  logic [HIDX_W-1:0] hash_index;
  logic [HVAL_W-1:0] hash_value;

  assign query_index = s_tdata[4:0];
  assign hash_index  = s_tdata[12:5];
  assign hash_value  = s_tdata[44:13];

  // Configuration registers.
  logic [QUSE_W-1:0] queries_in_use;
  logic [HUSE_W-1:0] hashes_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      queries_in_use <= QUSE_W'(32);
      hashes_in_use  <= HUSE_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERIES_IN_USE: queries_in_use <= cfg_wdata[QUSE_W-1:0];
        CFG_HASHES_IN_USE:  hashes_in_use  <= cfg_wdata[HUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Accepted transactions.
  logic accept;
  logic load_ok;
  logic cand_accept;
  logic cmp_ok;
  logic [QW-1:0] nq;

  assign accept      = s_tvalid && s_tready;
  assign load_ok     = accept && (s_tuser == REQ_LOAD) &&
                       (int'(query_index) < NUM_QUERIES) && (int'(hash_index) < NUM_HASHES);
  assign cand_accept = accept && (s_tuser == REQ_CANDIDATE);
  // Hashes beyond the configured or the built number are not compared.
  assign cmp_ok      = ({1'b0, hash_index} < hashes_in_use) && (int'(hash_index) < NUM_HASHES);
  assign nq          = (int'(queries_in_use) > NUM_QUERIES) ? QW'(NUM_QUERIES)
                                                             : QW'(queries_in_use);

  // Stage one: the candidate waits here while the cells read their signatures.
  logic          s0_valid;
  logic          s0_cmp;
  logic          s0_last;
  logic [VW-1:0] s0_value;
  logic [QW-1:0] s0_nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= cand_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_accept) begin
      s0_cmp   <= cmp_ok;
      s0_last  <= s_tlast;
      s0_value <= hash_value[VW-1:0];
      s0_nq    <= nq;
    end
  end

  // Result drain and input hold.
  logic          hold;
  logic          drain_active;
  logic [PW-1:0] pos;
  logic [QW-1:0] drain_nq;
  logic          snap;
  logic          out_take;
  logic          final_result;

  assign snap         = s0_valid && s0_last;
  assign out_take     = m_tvalid && m_tready;
  assign final_result = (QW'(pos) + QW'(1)) == drain_nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold         <= 1'b0;
      drain_active <= 1'b0;
      pos          <= '0;
      drain_nq     <= '0;
    end else begin
      if (cand_accept && s_tlast) begin
        hold <= 1'b1;
      end
      if (snap) begin
        pos      <= '0;
        drain_nq <= s0_nq;
        if (s0_nq != '0) begin
          drain_active <= 1'b1;
        end else begin
          // No queries in use: the counters are cleared and nothing is sent.
          hold <= 1'b0;
        end
      end else if (out_take) begin
        if (final_result) begin
          drain_active <= 1'b0;
          hold         <= 1'b0;
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

  assign s_tready = !hold;

  // Cell chain.
  lcc_ctrl_t        ctrl;
  logic [CNT_W-1:0] chain [NUM_QUERIES+1];

  assign ctrl.compare = s0_valid && s0_cmp;
  assign ctrl.snap    = snap;
  assign ctrl.shift   = out_take;
  assign chain[NUM_QUERIES] = '0;

  for (genvar i = 0; i < NUM_QUERIES; i++) begin : g_cell
    lcc_cell #(
      .VW    (VW),
      .DEPTH (NUM_HASHES),
      .LIMIT (LIMIT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cell_en   (int'(s0_nq) > i),
      .wr_en     (load_ok && (int'(query_index) == i)),
      .wr_addr   (AW'(hash_index)),
      .wr_data   (hash_value[VW-1:0]),
      .rd_en     (cand_accept),
      .rd_addr   (AW'(hash_index)),
      .cmp_value (s0_value),
      .shift_in  (chain[i+1]),
      .shift_out (chain[i])
    );
  end

  assign m_tvalid = drain_active;
  assign m_tdata  = {2'b00, chain[0], 5'(pos)};
  assign m_tlast  = final_result;

  // Results appear only while the input is held for the drain.
  a_result_under_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> hold)
    else $error("result offered while the input is open");

  // A capture with queries in use always starts a drain.
  a_snap_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (snap && (s0_nq != '0)) |=> (m_tvalid && (pos == '0)))
    else $error("capture did not start the result drain");

  // Taking the final result ends the drain and reopens the input.
  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (out_take && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("drain did not end after the final result");

  // The drain position never reaches the captured query count.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (QW'(pos) < drain_nq))
    else $error("drain position beyond the queries in use");

endmodule
`default_nettype wire
